// ===== src/vfjb_pkg.sv =====
// Shared types and constants for the video frame jitter buffer.
package vfjb_pkg;

  localparam int KEY_BITS  = 64;
  localparam int TIME_BITS = 64;

  localparam logic [7:0]  DELAY_MAX  = 8'd200;
  localparam logic [7:0]  DELAY_RST  = 8'd50;
  localparam logic [5:0]  FRAMES_RST = 6'd16;
  localparam logic [9:0]  US_PER_MS  = 10'd1000;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_SWEEP = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RC_STORED   = 3'd0,
    RC_STALE    = 3'd1,
    RC_DUP      = 3'd2,
    RC_RELEASED = 3'd3,
    RC_NOTREADY = 3'd4,
    RC_SWEPT    = 3'd5,
    RC_CLEARED  = 3'd6
  } rcode_t;

  typedef enum logic [1:0] {
    REG_DELAY   = 2'd0,
    REG_FRAMES  = 2'd1,
    REG_LATENCY = 2'd2
  } reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIM,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_WRITE,
    ST_POP,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

// ===== src/vfjb_store.sv =====
// Register file of sorted frame entries with one shared load and shift datapath.
module vfjb_store import vfjb_pkg::*; #(
  parameter int CAPACITY    = 32,
  parameter int HANDLE_BITS = 16,
  localparam int IW = $clog2(CAPACITY)
) (
  input  logic                   clk,
  input  logic [IW-1:0]          idx,
  input  logic                   move_down,
  input  logic                   move_up,
  input  logic                   load,
  input  logic [31:0]            ld_stream,
  input  logic [31:0]            ld_frame,
  input  logic [TIME_BITS-1:0]   ld_rx,
  input  logic [TIME_BITS-1:0]   ld_tx,
  input  logic [HANDLE_BITS-1:0] ld_handle,
  output logic [31:0]            rd_stream,
  output logic [31:0]            rd_frame,
  output logic [TIME_BITS-1:0]   rd_rx,
  output logic [TIME_BITS-1:0]   rd_tx,
  output logic [31:0]            head_stream,
  output logic [31:0]            head_frame,
  output logic [TIME_BITS-1:0]   head_rx,
  output logic [HANDLE_BITS-1:0] head_handle
);

  logic [31:0]            st [CAPACITY];
  logic [31:0]            fr [CAPACITY];
  logic [TIME_BITS-1:0]   rx [CAPACITY];
  logic [TIME_BITS-1:0]   tx [CAPACITY];
  logic [HANDLE_BITS-1:0] hd [CAPACITY];
  logic [IW-1:0]          idx_up;
  logic [IW-1:0]          idx_dn;

  assign idx_up = idx + IW'(1);
  assign idx_dn = idx - IW'(1);

  // move_down: entry idx takes entry idx+1; move_up: entry idx takes idx-1
  always_ff @(posedge clk) begin
    if (load) begin
      st[idx] <= ld_stream;
      fr[idx] <= ld_frame;
      rx[idx] <= ld_rx;
      tx[idx] <= ld_tx;
      hd[idx] <= ld_handle;
    end else if (move_down) begin
      st[idx] <= st[idx_up];
      fr[idx] <= fr[idx_up];
      rx[idx] <= rx[idx_up];
      tx[idx] <= tx[idx_up];
      hd[idx] <= hd[idx_up];
    end else if (move_up) begin
      st[idx] <= st[idx_dn];
      fr[idx] <= fr[idx_dn];
      rx[idx] <= rx[idx_dn];
      tx[idx] <= tx[idx_dn];
      hd[idx] <= hd[idx_dn];
    end
  end

  assign rd_stream   = st[idx];
  assign rd_frame    = fr[idx];
  assign rd_rx       = rx[idx];
  assign rd_tx       = tx[idx];
  assign head_stream = st[0];
  assign head_frame  = fr[0];
  assign head_rx     = rx[0];
  assign head_handle = hd[0];

endmodule

// ===== src/video_frame_jitter_buffer_top.sv =====
// Video frame jitter buffer: sorted frame store driven by a small sequencer.
// Trims, the key scan, entry shifts and the expiry sweep walk the store one entry a
// cycle, so a lowered limit that trims many heads or a sweep that expires many
// frames makes an item take longest.
// Throughput: one item at a time; in_stall is high from accept until the result is taken.
// Reset: synchronous rst empties the store, forgets the last release and
// restores delay 50 ms, limit 16 frames, expiry off.
module video_frame_jitter_buffer_top import vfjb_pkg::*; #(
  parameter int CAPACITY    = 32,
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             opcode,
  input  logic [31:0]            in_stream_id,
  input  logic [31:0]            in_frame_id,
  input  logic [63:0]            in_receive_time_us,
  input  logic [63:0]            in_send_time_us,
  input  logic [HANDLE_BITS-1:0] in_handle,
  input  logic [63:0]            now_us,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             result_code,
  output logic [5:0]             dropped_count,
  output logic [5:0]             buffered_count,
  output logic [7:0]             delay_report_ms,
  output logic [31:0]            out_stream_id,
  output logic [31:0]            out_frame_id,
  output logic [HANDLE_BITS-1:0] out_handle
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  logic [7:0]  target_delay;
  logic [5:0]  max_frames;
  logic [63:0] max_latency;

  op_t              op;
  logic [31:0]      sid, fid;
  logic [63:0]      rx_in, tx_in, now;
  logic [HANDLE_BITS-1:0] hnd;

  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [CW-1:0] ptr;
  logic [5:0]    dropped;
  logic          rel_valid;
  logic [31:0]   rel_stream, rel_frame;
  logic          dup;
  logic [17:0]   delay_us;

  logic [CW-1:0] lim;
  logic [IW-1:0] s_idx;
  logic          s_down, s_up, s_load;
  logic [31:0]   rd_stream, rd_frame, head_stream, head_frame;
  logic [63:0]   rd_rx, rd_tx, head_rx;
  logic [HANDLE_BITS-1:0] head_handle;
  logic [63:0]   base;
  logic          expd;
  logic          key_lt, key_eq;
  logic          pop_ok;

  vfjb_store #(.CAPACITY(CAPACITY), .HANDLE_BITS(HANDLE_BITS)) u_store (
    .clk(clk), .idx(s_idx), .move_down(s_down), .move_up(s_up), .load(s_load),
    .ld_stream(sid), .ld_frame(fid), .ld_rx(rx_in), .ld_tx(tx_in), .ld_handle(hnd),
    .rd_stream(rd_stream), .rd_frame(rd_frame), .rd_rx(rd_rx), .rd_tx(rd_tx),
    .head_stream(head_stream), .head_frame(head_frame),
    .head_rx(head_rx), .head_handle(head_handle)
  );

  always_comb begin
    if (int'(max_frames) > CAPACITY) lim = CW'(CAPACITY);
    else lim = CW'(max_frames);
  end

  assign key_lt = {rd_stream, rd_frame} < {sid, fid};
  assign key_eq = {rd_stream, rd_frame} == {sid, fid};
  assign base   = (rd_tx == 64'd0 || now < rd_tx) ? rd_rx : rd_tx;
  assign expd   = (max_latency != 64'd0) && (now > base) && ((now - base) > max_latency);
  assign pop_ok = (count != '0) && (now >= head_rx) &&
                  ((now - head_rx) >= 64'(delay_us));

  assign cfg_ready = (state == ST_IDLE);
  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign buffered_count  = 6'(count);
  assign delay_report_ms = target_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_delay <= DELAY_RST;
      max_frames   <= FRAMES_RST;
      max_latency  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELAY:   target_delay <= (cfg_data[7:0] > DELAY_MAX) ? DELAY_MAX : cfg_data[7:0];
        REG_FRAMES:  max_frames <= (cfg_data[5:0] == 6'd0) ? 6'd1 : cfg_data[5:0];
        REG_LATENCY: max_latency <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    delay_us <= 18'(target_delay) * 18'(US_PER_MS);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // sequencer
  always_comb begin
    state_next = state;
    s_idx  = ptr[IW-1:0];
    s_down = 1'b0;
    s_up   = 1'b0;
    s_load = 1'b0;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_TRIM;
      ST_TRIM: begin
        if (count > lim) begin
          if (ptr + CW'(1) < count) s_down = 1'b1;
        end else begin
          unique case (op)
            OP_PUSH:  state_next = ST_SCAN;
            OP_POP:   state_next = ST_POP;
            OP_SWEEP: state_next = ST_SWEEP;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN:   if (ptr >= count || !key_lt) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_DONE;
      ST_SHIFT: begin
        if (ptr + CW'(1) < count) s_down = 1'b1;
        else state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (ptr > pos) s_up = 1'b1;
        else begin
          s_load = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_POP: begin
        if ((ptr == '0 && !pop_ok) || ptr + CW'(1) >= count) state_next = ST_DONE;
        else s_down = 1'b1;
      end
      ST_SWEEP:  if (ptr >= count) state_next = ST_DONE;
      ST_DONE:   if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
    if (state == ST_DECIDE) begin
      if (!(rel_valid && sid == rel_stream && fid <= rel_frame) && !dup &&
          !(count >= lim && pos == '0)) begin
        state_next = (count >= lim) ? ST_SHIFT : ST_WRITE;
      end
    end
    if (state == ST_SWEEP && ptr < count && (ptr != pos || expd) &&
        ptr + CW'(1) < count) s_down = 1'b1;
  end

  // item registers and datapath control
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rel_valid  <= 1'b0;
      rel_stream <= '0;
      rel_frame  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_valid) begin
          op <= op_t'(opcode);
          sid <= in_stream_id; fid <= in_frame_id;
          rx_in <= in_receive_time_us; tx_in <= in_send_time_us;
          hnd <= in_handle; now <= now_us;
          ptr <= '0; dropped <= '0; dup <= 1'b0;
          out_stream_id <= '0; out_frame_id <= '0; out_handle <= '0;
        end
        ST_TRIM: begin
          if (count > lim) begin
            if (ptr + CW'(1) < count) ptr <= ptr + CW'(1);
            else begin
              count <= count - CW'(1);
              ptr <= '0;
            end
          end else begin
            ptr <= '0;
            if (op == OP_CLEAR) begin
              count <= '0; rel_valid <= 1'b0; rel_stream <= '0; rel_frame <= '0;
              result_code <= RC_CLEARED;
            end
            if (op == OP_POP) begin
              out_stream_id <= head_stream;
              out_frame_id  <= head_frame;
              out_handle    <= head_handle;
            end
          end
        end
        ST_SCAN: begin
          if (ptr >= count || !key_lt) begin
            pos <= ptr;
            dup <= (ptr < count) && key_eq;
          end else ptr <= ptr + CW'(1);
        end
        ST_DECIDE: begin
          ptr <= '0;
          if (rel_valid && sid == rel_stream && fid <= rel_frame) begin
            result_code <= RC_STALE; dropped <= 6'd1;
          end else if (dup) begin
            result_code <= RC_DUP; dropped <= 6'd1;
          end else begin
            result_code <= RC_STORED;
            if (count >= lim) begin
              dropped <= 6'd1;
              if (pos != '0) pos <= pos - CW'(1);
            end else ptr <= count;
          end
        end
        ST_SHIFT: begin
          if (ptr + CW'(1) < count) ptr <= ptr + CW'(1);
          else ptr <= count - CW'(1);
        end
        ST_WRITE: begin
          if (ptr > pos) ptr <= ptr - CW'(1);
          else count <= (dropped != '0) ? count : count + CW'(1);
        end
        ST_POP: begin
          if (ptr == '0 && !pop_ok) begin
            result_code <= RC_NOTREADY;
            out_stream_id <= '0; out_frame_id <= '0; out_handle <= '0;
          end else if (ptr + CW'(1) >= count) begin
            result_code <= RC_RELEASED;
            rel_valid <= 1'b1; rel_stream <= out_stream_id; rel_frame <= out_frame_id;
            count <= count - CW'(1);
          end else ptr <= ptr + CW'(1);
        end
        ST_SWEEP: begin
          result_code <= RC_SWEPT;
          if (ptr < count) begin
            if (ptr != pos || expd) begin
              // compact one slot at a time, restart at the gap
              if (ptr + CW'(1) < count) ptr <= ptr + CW'(1);
              else begin
                count <= count - CW'(1);
                dropped <= dropped + 6'd1;
                ptr <= pos;
              end
            end else begin
              ptr <= ptr + CW'(1);
              pos <= ptr + CW'(1);
            end
          end
        end
        default: ;
      endcase
      if (state == ST_TRIM && count <= lim && op == OP_SWEEP) pos <= '0;
    end
  end

  assign dropped_count = dropped;

`ifndef ASSERT_OFF
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("entry count above capacity");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !out_valid) else $error("config taken while result pending");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(count)))
    else $error("result dropped while stalled");
`endif

endmodule
